/* rtl/core/bst_pkg.sv */
// bst_pkg: shared types and constants for the bezier segment tessellator
// used by the front, queue, back and top-level modules
`timescale 1ns / 1ps
package bst_pkg;
   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAX_STEPS = 63;
   localparam int STEPS_W   = 6;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int DIMS      = 4;
   localparam int SEG_PTS   = 4;
   localparam int QDEPTH    = 2;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = DIFF_W + T_W;

   localparam logic [0:0] REG_STEPS = 1'b0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [DIMS-1:0] point_type;

   typedef struct packed {
      point_type [SEG_PTS-1:0] pts;
      logic [1:0]              deg;   // number of lerp levels, 1..3
   } seg_type;

   // one lerp with a floored product
   function automatic coord_type lerp(input coord_type a, input coord_type b,
                                      input logic [T_W-1:0] t);
      logic signed [DIFF_W-1:0] diff;
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] sum;
      diff = DIFF_W'(b) - DIFF_W'(a);
      prod = PROD_W'(diff) * $signed({1'b0, t});
      sum  = PROD_W'(a) + (prod >>> FRAC_BITS);
      return sum[COORD_W-1:0];
   endfunction
endpackage

/* rtl/core/bst_front.sv */
// bst_front: gathers control points into segments and pushes them on the queue
// depends on bst_pkg
`timescale 1ns / 1ps
module bst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bst_pkg::point_type pt,
   input  logic              end_of_curve,
   output logic              seg_valid,
   input  logic              seg_ready,
   output bst_pkg::seg_type  seg
);
   import bst_pkg::*;

   point_type [SEG_PTS-1:0] held_ff, held_in;
   logic [1:0] cnt_ff, cnt_in;
   logic full_ff, full_in;
   seg_type seg_ff, seg_in;
   logic emit;
   logic [2:0] n;

   assign req_ready = !full_ff || seg_ready;
   assign seg_valid = full_ff;
   assign seg = seg_ff;
   assign n = {1'b0, cnt_ff} + 3'd1;

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      seg_in  = seg_ff;
      full_in = full_ff && !seg_ready;
      emit    = 1'b0;
      if (req_valid && req_ready) begin
         held_in[cnt_ff] = pt;
         seg_in.pts = held_in;
         seg_in.deg = cnt_ff;
         if (n == 3'd4) begin
            emit = 1'b1;
            held_in[0] = pt;
            cnt_in = end_of_curve ? 2'd0 : 2'd1;
         end else if (end_of_curve) begin
            emit = (n >= 3'd2);
            cnt_in = 2'd0;
         end else begin
            cnt_in = n[1:0];
         end
         if (emit) full_in = 1'b1;
         else seg_in = seg_ff;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      seg_ff  <= seg_in;
      if (reset) begin
         cnt_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         full_ff <= full_in;
      end
   end
endmodule

/* rtl/core/bst_queue.sv */
// bst_queue: short segment queue between front and back
// depends on bst_pkg
`timescale 1ns / 1ps
module bst_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bst_pkg::seg_type in_seg,
   output logic             out_valid,
   input  logic             out_ready,
   output bst_pkg::seg_type out_seg
);
   import bst_pkg::*;

   seg_type mem_ff [QDEPTH];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'(QDEPTH);
   assign out_valid = cnt_ff != 2'd0;
   assign out_seg   = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_seg;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/core/bst_back.sv */
// bst_back: evaluates one segment at steps+1 values of t, one lerp level a stage
// depends on bst_pkg
`timescale 1ns / 1ps
module bst_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [bst_pkg::STEPS_W-1:0] steps,
   input  logic               seg_valid,
   output logic               seg_ready,
   input  bst_pkg::seg_type   seg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bst_pkg::point_type q,
   output logic               last_of_run
);
   import bst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001, S_DIV = 3'b010, S_EVAL = 3'b100
   } state_type;

   state_type state_ff, state_in;
   seg_type cur_ff, cur_in;
   logic [STEPS_W-1:0] s_ff, s_in, i_ff, i_in;
   // restoring divider for t = floor(i * 2^frac / s)
   logic [STEPS_W+FRAC_BITS-1:0] num_ff, num_in;
   logic [STEPS_W-1:0] rem_ff, rem_in;
   logic [T_W-1:0] quo_ff, quo_in;
   logic [4:0] bit_ff, bit_in;
   logic [STEPS_W:0] trial;
   // lerp pipeline
   point_type [2:0] l1_ff, l1_in;
   point_type [1:0] l2_ff, l2_in;
   point_type l3_ff, l3_in;
   logic [T_W-1:0] t_ff, t_in;
   logic [1:0] lv_ff, lv_in;
   logic last_ff, last_in;
   logic oval_ff, oval_in;

   assign seg_ready   = state_ff == S_IDLE;
   assign rsp_valid   = oval_ff;
   assign q           = l3_ff;
   assign last_of_run = last_ff;
   assign trial = {rem_ff, num_ff[STEPS_W+FRAC_BITS-1]} - {1'b0, s_ff};

   always_comb begin
      state_in = state_ff; cur_in = cur_ff; s_in = s_ff; i_in = i_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; bit_in = bit_ff;
      l1_in = l1_ff; l2_in = l2_ff; l3_in = l3_ff; t_in = t_ff;
      lv_in = lv_ff; last_in = last_ff; oval_in = oval_ff;
      if (oval_ff && rsp_ready) oval_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (seg_valid) begin
            cur_in = seg;
            s_in = (steps == '0) ? STEPS_W'(1) : steps;
            i_in = '0;
            num_in = '0; rem_in = '0; quo_in = '0;
            bit_in = 5'(STEPS_W + FRAC_BITS);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (bit_ff != 5'd0) begin
               num_in = num_ff << 1;
               if (!trial[STEPS_W]) begin
                  rem_in = trial[STEPS_W-1:0];
                  quo_in = {quo_ff[T_W-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[STEPS_W-2:0], num_ff[STEPS_W+FRAC_BITS-1]};
                  quo_in = {quo_ff[T_W-2:0], 1'b0};
               end
               bit_in = bit_ff - 5'd1;
            end else begin
               t_in = quo_ff;
               lv_in = 2'd0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (lv_ff)
               2'd0: begin
                  for (int d = 0; d < DIMS; d++)
                     for (int j = 0; j < 3; j++)
                        l1_in[j][d] = lerp(cur_ff.pts[j][d], cur_ff.pts[j+1][d], t_ff);
                  lv_in = 2'd1;
               end
               2'd1: begin
                  for (int d = 0; d < DIMS; d++)
                     for (int j = 0; j < 2; j++)
                        l2_in[j][d] = lerp(l1_ff[j][d], l1_ff[j+1][d], t_ff);
                  lv_in = 2'd2;
               end
               default: begin
                  // final level: hold until the output register is free
                  if (!oval_ff || rsp_ready) begin
                     for (int d = 0; d < DIMS; d++)
                        l3_in[d] = (cur_ff.deg == 2'd1) ? l1_ff[0][d] :
                                   (cur_ff.deg == 2'd2) ? l2_ff[0][d] :
                                   lerp(l2_ff[0][d], l2_ff[1][d], t_ff);
                     oval_in = 1'b1;
                     last_in = i_ff == s_ff;
                     if (i_ff == s_ff) state_in = S_IDLE;
                     else begin
                        i_in = i_ff + STEPS_W'(1);
                        num_in = {i_in, {FRAC_BITS{1'b0}}};
                        rem_in = '0; quo_in = '0;
                        bit_in = 5'(STEPS_W + FRAC_BITS);
                        state_in = S_DIV;
                     end
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; s_ff <= s_in; i_ff <= i_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; bit_ff <= bit_in;
      l1_ff <= l1_in; l2_ff <= l2_in; l3_ff <= l3_in; t_ff <= t_in;
      lv_ff <= lv_in; last_ff <= last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         oval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         oval_ff  <= oval_in;
      end
   end
endmodule

/* rtl/core/bezier_segment_tessellator.sv */
// bezier_segment_tessellator: top level, csr port, front, queue and back
// depends on bst_pkg, bst_front, bst_queue, bst_back
`timescale 1ns / 1ps
// Usage:
//  req_* takes 4D Q16.16 control points; req_end_of_curve marks the last one.
//  Every third new point closes a cubic segment sharing its start with the
//  previous end; a curve end closes a shorter segment of 2 or 3 points, a lone
//  point gives nothing.
//  rsp_* delivers steps+1 points per segment (t = i/steps, de Casteljau),
//  rsp_last_of_run set on the final one.
//  p* signals form an APB-style port; register 0 at address 0 is steps (reset 16,
//  0 is taken as 1). Write it only while idle.
//  Flow: each output point runs the serial t divider and then the lerp
//  levels in turn, and the back end takes a new segment only after the last
//  point of the current one. The front accepts a point per cycle until the
//  two-entry segment queue and its own segment register are full.
//  Reset clears the point count, the queue and the output register; no
//  clearing pass. A stalled receiver holds rsp_*; the back end then waits
//  and the front keeps taking points until the queue and its register fill.
module bezier_segment_tessellator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_px,
   input  logic signed [31:0] req_py,
   input  logic signed [31:0] req_pz,
   input  logic signed [31:0] req_pw,
   input  logic        req_end_of_curve,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_qx,
   output logic signed [31:0] rsp_qy,
   output logic signed [31:0] rsp_qz,
   output logic signed [31:0] rsp_qw,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bst_pkg::*;

   logic [STEPS_W-1:0] steps_ff, steps_in;
   point_type pt, q;
   seg_type f_seg, b_seg;
   logic f_valid, f_ready, b_valid, b_ready;

   assign pready = 1'b1;
   assign prdata = (paddr[1:0] == {REG_STEPS, 1'b0}) ? 32'(steps_ff) : 32'd0;
   assign steps_in = (psel && penable && pwrite && paddr == {REG_STEPS, 1'b0})
                     ? pwdata[STEPS_W-1:0] : steps_ff;

   always_ff @(posedge clock) begin
      if (reset) steps_ff <= STEPS_W'(16);
      else steps_ff <= steps_in;
   end

   assign pt[0] = req_px; assign pt[1] = req_py;
   assign pt[2] = req_pz; assign pt[3] = req_pw;

   bst_front u_front (
      .clock, .reset, .req_valid, .req_ready, .pt, .end_of_curve(req_end_of_curve),
      .seg_valid(f_valid), .seg_ready(f_ready), .seg(f_seg)
   );

   bst_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_seg(f_seg),
      .out_valid(b_valid), .out_ready(b_ready), .out_seg(b_seg)
   );

   bst_back u_back (
      .clock, .reset, .steps(steps_ff), .seg_valid(b_valid), .seg_ready(b_ready),
      .seg(b_seg), .rsp_valid, .rsp_ready, .q, .last_of_run(rsp_last_of_run)
   );

   assign rsp_qx = q[0]; assign rsp_qy = q[1];
   assign rsp_qz = q[2]; assign rsp_qw = q[3];
endmodule
